// ===== src/tmcw_pkg.sv =====
package tmcw_pkg;

  localparam int unsigned Columns = 80;
  localparam int unsigned Rows    = 25;
  localparam int unsigned Cells   = Columns * Rows;

  localparam int unsigned ColW    = $clog2(Columns);
  localparam int unsigned RowW    = $clog2(Rows);
  localparam int unsigned AddrW   = $clog2(Cells);
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CellW   = 2 * ByteW;
  localparam int unsigned ActW    = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  localparam logic [ByteW-1:0] BlankByte   = 8'h20;
  localparam logic [ByteW-1:0] NewlineByte = 8'h0a;

  typedef enum logic [ActW-1:0] {
    ACT_PRINT_CUR = 3'd0,
    ACT_PRINT_POS = 3'd1,
    ACT_MOVE      = 3'd2,
    ACT_CLEAR     = 3'd3,
    ACT_READ      = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_PRINT_CUR,
    OP_PRINT_POS,
    OP_MOVE,
    OP_CLEAR,
    OP_READ
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEFAULT_ATTR  = 2'd0,
    CFG_CURSOR_HIDDEN = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    op_e              op;
    logic             newline;
    logic [ByteW-1:0] ch;
    logic [ByteW-1:0] attr;
    logic [ColW-1:0]  col;
    logic [RowW-1:0]  row;
  } cmd_t;

  typedef struct packed {
    logic [ByteW-1:0] default_attr;
    logic             cursor_hidden;
  } cfg_t;

  // Row-major cell index; multiply by a constant only.
  function automatic logic [AddrW-1:0] cell_addr(logic [ColW-1:0] col, logic [RowW-1:0] row);
    logic [AddrW-1:0] base;
    base = AddrW'(row) * AddrW'(Columns);
    return base + AddrW'(col);
  endfunction

endpackage

// ===== src/tmcw_ram.sv =====
module tmcw_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/tmcw_front.sv =====
module tmcw_front (
  input  logic [tmcw_pkg::ActW-1:0]  action_i,
  input  logic [tmcw_pkg::ByteW-1:0] character_i,
  input  logic [tmcw_pkg::ByteW-1:0] attribute_i,
  input  logic [tmcw_pkg::ColW-1:0]  col_i,
  input  logic [tmcw_pkg::RowW-1:0]  row_i,
  output tmcw_pkg::cmd_t             cmd_o
);
  import tmcw_pkg::*;

  logic [ColW-1:0] col_clamped;
  logic [RowW-1:0] row_clamped;

  // Saturate the position to the last column and row.
  assign col_clamped = (col_i > ColW'(Columns - 1)) ? ColW'(Columns - 1) : col_i;
  assign row_clamped = (row_i > RowW'(Rows - 1)) ? RowW'(Rows - 1) : row_i;

  always_comb begin
    cmd_o.newline = (character_i == NewlineByte);
    cmd_o.ch      = character_i;
    cmd_o.attr    = attribute_i;
    cmd_o.col     = col_clamped;
    cmd_o.row     = row_clamped;
    unique case (action_e'(action_i))
      ACT_PRINT_CUR: cmd_o.op = OP_PRINT_CUR;
      ACT_PRINT_POS: cmd_o.op = OP_PRINT_POS;
      ACT_MOVE:      cmd_o.op = OP_MOVE;
      ACT_CLEAR:     cmd_o.op = OP_CLEAR;
      ACT_READ:      cmd_o.op = OP_READ;
      default:       cmd_o.op = OP_NOP;
    endcase
  end

endmodule

// ===== src/tmcw_cmd_queue.sv =====
module tmcw_cmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tmcw_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output tmcw_pkg::cmd_t cmd_o
);
  import tmcw_pkg::*;

  cmd_t             entry_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + QCntW'(do_push) - QCntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= QCntW'(QDepth))
    else $error("command queue count overflow");

endmodule

// ===== src/tmcw_back.sv =====
module tmcw_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tmcw_pkg::cfg_t             cfg_i,
  input  logic                       cmd_valid_i,
  input  tmcw_pkg::cmd_t             cmd_i,
  output logic                       cmd_pop_o,
  output logic                       res_valid_o,
  input  logic                       res_pop_i,
  output logic [tmcw_pkg::ColW-1:0]  cursor_col_o,
  output logic [tmcw_pkg::RowW-1:0]  cursor_row_o,
  output logic [tmcw_pkg::ByteW-1:0] cell_char_o,
  output logic [tmcw_pkg::ByteW-1:0] cell_attribute_o,
  output logic                       scrolled_o,
  output logic                       cursor_shown_o
);
  import tmcw_pkg::*;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StScroll = 3'd1;
  localparam logic [2:0] StFill   = 3'd2;
  localparam logic [2:0] StClear  = 3'd3;
  localparam logic [2:0] StDone   = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [ColW-1:0]  cur_col_q, cur_col_d;
  logic [RowW-1:0]  cur_row_q, cur_row_d;
  logic [AddrW-1:0] cnt_q, cnt_d;
  logic             pend_q;
  logic [AddrW-1:0] pend_addr_q;
  logic             scrolled_q, scrolled_d;
  logic             is_read_q, is_read_d;

  logic             out_valid_q;
  logic [ColW-1:0]  out_col_q;
  logic [RowW-1:0]  out_row_q;
  logic [ByteW-1:0] out_char_q, out_attr_q;
  logic             out_scrolled_q, out_shown_q;
  logic             out_load;

  logic [ColW-1:0]  where_col;
  logic [RowW-1:0]  where_row;
  logic [AddrW-1:0] where_addr;
  logic [ByteW-1:0] attr_res;
  logic             wrap, past_end;

  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [CellW-1:0] ram_wdata, ram_rdata;

  tmcw_ram #(
    .Width (CellW),
    .Depth (Cells)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign where_col  = (cmd_i.op == OP_PRINT_CUR) ? cur_col_q : cmd_i.col;
  assign where_row  = (cmd_i.op == OP_PRINT_CUR) ? cur_row_q : cmd_i.row;
  assign where_addr = cell_addr(where_col, where_row);
  assign attr_res   = (cmd_i.attr == '0) ? cfg_i.default_attr : cmd_i.attr;
  assign wrap       = cmd_i.newline || (where_col == ColW'(Columns - 1));
  assign past_end   = wrap && (where_row == RowW'(Rows - 1));
  assign cmd_pop_o  = (state_q == StIdle) && cmd_valid_i;
  assign out_load   = (state_q == StDone) && (!out_valid_q || res_pop_i);

  always_comb begin
    state_d    = state_q;
    cur_col_d  = cur_col_q;
    cur_row_d  = cur_row_q;
    cnt_d      = cnt_q;
    scrolled_d = scrolled_q;
    is_read_d  = is_read_q;
    ram_we     = 1'b0;
    ram_waddr  = where_addr;
    ram_wdata  = {attr_res, cmd_i.ch};
    ram_re     = 1'b0;
    ram_raddr  = where_addr;

    // A row copy is written back in the cycle after its read.
    if (pend_q) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr_q;
      ram_wdata = ram_rdata;
    end

    unique case (state_q)
      StIdle: begin
        if (cmd_valid_i) begin
          scrolled_d = 1'b0;
          is_read_d  = (cmd_i.op == OP_READ);
          state_d    = StDone;
          unique case (cmd_i.op) inside
            OP_PRINT_CUR, OP_PRINT_POS: begin
              ram_we = !cmd_i.newline;
              if (wrap) begin
                cur_col_d = '0;
                cur_row_d = past_end ? where_row : where_row + RowW'(1);
              end else begin
                cur_col_d = where_col + ColW'(1);
                cur_row_d = where_row;
              end
              if (past_end) begin
                scrolled_d = 1'b1;
                cnt_d      = AddrW'(Columns);
                state_d    = StScroll;
              end
            end
            OP_MOVE: begin
              cur_col_d = cmd_i.col;
              cur_row_d = cmd_i.row;
            end
            OP_CLEAR: begin
              cur_col_d = '0;
              cur_row_d = '0;
              cnt_d     = '0;
              state_d   = StClear;
            end
            OP_READ: begin
              ram_re = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      StScroll: begin
        ram_re    = 1'b1;
        ram_raddr = cnt_q;
        if (cnt_q == AddrW'(Cells - 1)) begin
          cnt_d   = AddrW'(Cells - Columns);
          state_d = StFill;
        end else begin
          cnt_d = cnt_q + AddrW'(1);
        end
      end
      StFill: begin
        if (!pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_q;
          ram_wdata = {BlankByte, BlankByte};
          if (cnt_q == AddrW'(Cells - 1)) begin
            state_d = StDone;
          end else begin
            cnt_d = cnt_q + AddrW'(1);
          end
        end
      end
      StClear: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = {cfg_i.default_attr, BlankByte};
        if (cnt_q == AddrW'(Cells - 1)) begin
          state_d = StDone;
        end else begin
          cnt_d = cnt_q + AddrW'(1);
        end
      end
      StDone: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      scrolled_q  <= 1'b0;
      is_read_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_col_q  <= cur_col_d;
      cur_row_q  <= cur_row_d;
      cnt_q      <= cnt_d;
      pend_q     <= (state_q == StScroll);
      scrolled_q <= scrolled_d;
      is_read_q  <= is_read_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q <= cnt_q - AddrW'(Columns);
    if (out_load) begin
      out_col_q      <= cur_col_q;
      out_row_q      <= cur_row_q;
      out_char_q     <= is_read_q ? ram_rdata[ByteW-1:0] : '0;
      out_attr_q     <= is_read_q ? ram_rdata[CellW-1:ByteW] : '0;
      out_scrolled_q <= scrolled_q;
      out_shown_q    <= !cfg_i.cursor_hidden;
    end
  end

  assign res_valid_o      = out_valid_q;
  assign cursor_col_o     = out_col_q;
  assign cursor_row_o     = out_row_q;
  assign cell_char_o      = out_char_q;
  assign cell_attribute_o = out_attr_q;
  assign scrolled_o       = out_scrolled_q;
  assign cursor_shown_o   = out_shown_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_col_q < ColW'(Columns)) && (cur_row_q < RowW'(Rows)))
    else $error("cursor outside the buffer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> $past(state_q == StScroll))
    else $error("row copy write without a preceding read");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> !pend_q)
    else $error("new item taken while a row copy is in flight");

endmodule

// ===== src/text_mode_console_writer.sv =====
// Channel  | Handshake                      | Payload
// ---------+--------------------------------+--------------------------------------------
// input    | push / full                    | action, character, attribute, col, row
// result   | empty / pop                    | cursor_col/row, cell_char/attribute, flags
// config   | cfg_valid_i / cfg_ready_o      | cfg_index_i, cfg_data_i
//
// Print, move, read and unused actions go from idle straight to the done state
// in the back end. Clear and a scrolling print step through the cells and are
// bound by the single write port of the cell RAM (one cell per cycle).
// A 2-entry item queue and a 1-entry result register decouple both sides.
// Reset clears cursor and control state; cell contents stay undefined.
module text_mode_console_writer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [tmcw_pkg::ActW-1:0]      action_i,
  input  logic [tmcw_pkg::ByteW-1:0]     character_i,
  input  logic [tmcw_pkg::ByteW-1:0]     attribute_i,
  input  logic [tmcw_pkg::ColW-1:0]      col_i,
  input  logic [tmcw_pkg::RowW-1:0]      row_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [tmcw_pkg::ColW-1:0]      cursor_col_o,
  output logic [tmcw_pkg::RowW-1:0]      cursor_row_o,
  output logic [tmcw_pkg::ByteW-1:0]     cell_char_o,
  output logic [tmcw_pkg::ByteW-1:0]     cell_attribute_o,
  output logic                           scrolled_o,
  output logic                           cursor_shown_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tmcw_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tmcw_pkg::ByteW-1:0]     cfg_data_i
);
  import tmcw_pkg::*;

  cfg_t cfg_q;
  cmd_t front_cmd, queue_cmd;
  logic queue_valid, queue_pop, res_valid;

  // Config writes are always taken; unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.default_attr  <= ByteW'(15);
      cfg_q.cursor_hidden <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DEFAULT_ATTR:  cfg_q.default_attr  <= cfg_data_i;
        CFG_CURSOR_HIDDEN: cfg_q.cursor_hidden <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Front: decode the action and clamp the position.
  tmcw_front u_front (
    .action_i    (action_i),
    .character_i (character_i),
    .attribute_i (attribute_i),
    .col_i       (col_i),
    .row_i       (row_i),
    .cmd_o       (front_cmd)
  );

  // Hold decoded items until the back end is free.
  tmcw_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (queue_pop),
    .valid_o (queue_valid),
    .cmd_o   (queue_cmd)
  );

  // Back: carry out the item against the cell RAM and cursor.
  tmcw_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .cmd_valid_i      (queue_valid),
    .cmd_i            (queue_cmd),
    .cmd_pop_o        (queue_pop),
    .res_valid_o      (res_valid),
    .res_pop_i        (pop),
    .cursor_col_o     (cursor_col_o),
    .cursor_row_o     (cursor_row_o),
    .cell_char_o      (cell_char_o),
    .cell_attribute_o (cell_attribute_o),
    .scrolled_o       (scrolled_o),
    .cursor_shown_o   (cursor_shown_o)
  );

  assign empty = !res_valid;

endmodule
